/* rtl/core/hebp_pkg.sv */
// ----------------------------------------------------------------------------
// hebp_pkg
// Shared types and constants of the Huffman encoder bit packer.
// ----------------------------------------------------------------------------
package hebp_pkg;

    localparam int ACT_W  = 2;
    localparam int SYM_W  = 8;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int PAD_W  = 3;
    localparam int DEPTH  = 1 << SYM_W;

    // The packing window is the partial byte followed by one code word.
    localparam int BUF_W  = BYTE_W + VAL_W;
    localparam int QCNT_W = 3;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENC   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

    // Control of the item that waits between the table read and the packer.
    typedef struct packed {
        logic vld;
        logic flush;
    } t_stage;

endpackage

/* rtl/core/huffman_encoder_bit_packer.sv */
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer
// Packs variable-length Huffman codes MSB first into bytes from a
// 256-entry code table.
// ----------------------------------------------------------------------------
// A load beat writes one table entry; back-to-back loads run at one per cycle
// while o_ready is high. An encode beat reads the table; an encode or flush
// beat then enters the packer, which merges the code with the pending bits
// and emits the resulting bytes through the output register at one per cycle
// while i_ready is high. An encode yields zero to four bytes and a flush one
// result; the next item enters the packer once the queue is empty or as its
// last byte moves to the output register. A result passes through the table
// read register, the byte queue and the output register. The table needs no
// clearing pass after reset: entries never loaded read as length zero.
// ----------------------------------------------------------------------------
module huffman_encoder_bit_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hebp_pkg::ACT_W-1:0]  i_action,
    input  logic [hebp_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hebp_pkg::VAL_W-1:0]  i_code_value,
    input  logic [hebp_pkg::LEN_W-1:0]  i_code_length,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hebp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_byte_valid,
    output logic [hebp_pkg::PAD_W-1:0]  o_pad_bits,
    output logic                        o_last_of_run
);

    localparam int LenLimit = (MAX_CODE_LEN < hebp_pkg::VAL_W) ? MAX_CODE_LEN
                                                               : hebp_pkg::VAL_W;

    hebp_pkg::t_stage            r_stage;
    logic                        take;
    logic                        accept;
    logic                        wr_en;
    logic                        rd_en;
    logic [hebp_pkg::LEN_W-1:0]  len_sat;
    logic [hebp_pkg::VAL_W-1:0]  code_al;
    logic [hebp_pkg::LEN_W-1:0]  rd_len;
    logic [hebp_pkg::VAL_W-1:0]  rd_code;

    assign o_ready = !r_stage.vld || take;
    assign accept  = i_valid && o_ready;
    assign wr_en   = accept && (i_action == hebp_pkg::ACT_LOAD);
    assign rd_en   = accept && (i_action == hebp_pkg::ACT_ENC);

    // The code is stored left-aligned so bits above its length fall away.
    always_comb begin
        len_sat = (i_code_length > hebp_pkg::LEN_W'(LenLimit))
                ? hebp_pkg::LEN_W'(LenLimit) : i_code_length;
        code_al = i_code_value << (hebp_pkg::LEN_W'(hebp_pkg::VAL_W) - len_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (accept) begin
            r_stage.vld   <= (i_action == hebp_pkg::ACT_ENC)
                          || (i_action == hebp_pkg::ACT_FLUSH);
            r_stage.flush <= (i_action == hebp_pkg::ACT_FLUSH);
        end else if (take) begin
            r_stage.vld <= 1'b0;
        end
    end

    hebp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_symbol),
        .i_wr_len  (len_sat),
        .i_wr_code (code_al),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_symbol),
        .o_rd_len  (rd_len),
        .o_rd_code (rd_code)
    );

    hebp_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (r_stage),
        .i_len         (rd_len),
        .i_code        (rd_code),
        .o_take        (take),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_pad_bits    (o_pad_bits),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* rtl/core/hebp_table.sv */
// ----------------------------------------------------------------------------
// hebp_table
// Code table: 256 entries of length and left-aligned code word in one
// synchronous memory, with a valid bit per entry that reset clears.
// ----------------------------------------------------------------------------
module hebp_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [hebp_pkg::SYM_W-1:0] i_wr_addr,
    input  logic [hebp_pkg::LEN_W-1:0] i_wr_len,
    input  logic [hebp_pkg::VAL_W-1:0] i_wr_code,
    input  logic                       i_rd_en,
    input  logic [hebp_pkg::SYM_W-1:0] i_rd_addr,
    output logic [hebp_pkg::LEN_W-1:0] o_rd_len,
    output logic [hebp_pkg::VAL_W-1:0] o_rd_code
);

    logic [hebp_pkg::LEN_W+hebp_pkg::VAL_W-1:0] r_mem [hebp_pkg::DEPTH];
    logic [hebp_pkg::LEN_W+hebp_pkg::VAL_W-1:0] r_rd_data;
    logic [hebp_pkg::DEPTH-1:0]                 r_ent_vld;
    logic                                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_len, i_wr_code};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ent_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_ent_vld[i_rd_addr];
            end
        end
    end

    // An entry never loaded reads as a symbol without a code.
    assign o_rd_len  = r_rd_vld ? r_rd_data[hebp_pkg::LEN_W+hebp_pkg::VAL_W-1:hebp_pkg::VAL_W]
                                : '0;
    assign o_rd_code = r_rd_vld ? r_rd_data[hebp_pkg::VAL_W-1:0] : '0;

endmodule

/* rtl/core/hebp_packer.sv */
// ----------------------------------------------------------------------------
// hebp_packer
// Bit accumulator, byte queue and output register. A code word is merged
// with the pending bits; full bytes drain one per cycle unless i_ready stalls.
// ----------------------------------------------------------------------------
module hebp_packer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hebp_pkg::t_stage            i_stage,
    input  logic [hebp_pkg::LEN_W-1:0]  i_len,
    input  logic [hebp_pkg::VAL_W-1:0]  i_code,
    output logic                        o_take,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hebp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_byte_valid,
    output logic [hebp_pkg::PAD_W-1:0]  o_pad_bits,
    output logic                        o_last_of_run
);

    logic [hebp_pkg::BYTE_W-1:0]  r_acc;
    logic [hebp_pkg::PAD_W-1:0]   r_pend;
    logic [hebp_pkg::VAL_W-1:0]   r_q;
    logic [hebp_pkg::QCNT_W-1:0]  r_qcnt;
    logic                         r_qflush;
    logic                         r_qbv;
    logic [hebp_pkg::PAD_W-1:0]   r_qpad;
    logic                         r_o_vld;
    logic [hebp_pkg::BYTE_W-1:0]  r_o_byte;
    logic                         r_o_bvalid;
    logic [hebp_pkg::PAD_W-1:0]   r_o_pad;
    logic                         r_o_last;

    logic                         pop;
    logic [hebp_pkg::BUF_W-1:0]   merged;
    logic [hebp_pkg::BUF_W-1:0]   rest;
    logic [hebp_pkg::LEN_W-1:0]   total;
    logic [hebp_pkg::QCNT_W-1:0]  nbytes;

    assign pop    = (r_qcnt != '0) && (!r_o_vld || i_ready);
    assign o_take = i_stage.vld && ((r_qcnt == '0) || ((r_qcnt == 3'd1) && pop));

    // Pending bits sit at the top of r_acc; the code word is already
    // left-aligned, so it only moves down past the pending bits.
    always_comb begin
        merged = {r_acc, {hebp_pkg::VAL_W{1'b0}}}
               | ({i_code, {hebp_pkg::BYTE_W{1'b0}}} >> r_pend);
        total  = {{(hebp_pkg::LEN_W-hebp_pkg::PAD_W){1'b0}}, r_pend} + i_len;
        nbytes = total[hebp_pkg::LEN_W-1:hebp_pkg::PAD_W];
        rest   = merged << {nbytes, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
            r_qcnt <= '0;
        end else if (o_take) begin
            if (i_stage.flush) begin
                r_qcnt <= 3'd1;
                r_acc  <= '0;
                r_pend <= '0;
            end else begin
                r_qcnt <= nbytes;
                r_acc  <= rest[hebp_pkg::BUF_W-1 -: hebp_pkg::BYTE_W];
                r_pend <= total[hebp_pkg::PAD_W-1:0];
            end
        end else if (pop) begin
            r_qcnt <= r_qcnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_qflush <= i_stage.flush;
            r_qbv    <= (r_pend != '0);
            r_qpad   <= 3'd0 - r_pend;
            if (i_stage.flush) begin
                r_q <= {r_acc, {(hebp_pkg::VAL_W-hebp_pkg::BYTE_W){1'b0}}};
            end else begin
                r_q <= merged[hebp_pkg::BUF_W-1:hebp_pkg::BYTE_W];
            end
        end else if (pop) begin
            r_q <= r_q << hebp_pkg::BYTE_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (pop) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_byte   <= r_q[hebp_pkg::VAL_W-1 -: hebp_pkg::BYTE_W];
            r_o_bvalid <= r_qflush ? r_qbv : 1'b1;
            r_o_pad    <= r_qflush ? r_qpad : '0;
            r_o_last   <= (r_qcnt == 3'd1);
        end
    end

    assign o_valid       = r_o_vld;
    assign o_out_byte    = r_o_byte;
    assign o_byte_valid  = r_o_bvalid;
    assign o_pad_bits    = r_o_pad;
    assign o_last_of_run = r_o_last;

`ifndef SYNTH
    // One code word never yields more than four bytes.
    a_qcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= 3'd4)
        else $error("byte queue count above four");

    // Bits of the partial byte below the pending ones stay clear.
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc & (8'hFF >> r_pend)) == 8'h00)
        else $error("partial byte holds stray bits");

    // The beat that drains the queue closes the run.
    a_last_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_qcnt == 3'd1)) |=> (r_o_vld && r_o_last))
        else $error("last beat of a run not marked");

    // An empty flush carries neither byte nor pad count.
    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o_bvalid) |-> ((r_o_byte == 8'h00) && (r_o_pad == 3'd0)))
        else $error("empty flush beat carries data");
`endif

endmodule
